// File: sv/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types and widths for the line pixel generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

	localparam int unsigned CoordW = 6;
	localparam int unsigned ColorW = 24;
	localparam int unsigned ErrW   = CoordW + 3;

	typedef logic [CoordW-1:0] coord_t;
	typedef logic [ColorW-1:0] color_t;

	typedef struct packed {
		logic load;
		logic step;
	} lpg_cmd_t;

	typedef struct packed {
		logic last;
	} lpg_status_t;

endpackage

// File: sv/line_pixel_generator.sv
// ----------------------------------------------------------------------------
// line_pixel_generator
// Bresenham line rasterizer: one line request in, one pixel request out per
// point of the line, from the first endpoint to the second.
// ----------------------------------------------------------------------------
// The line request is loaded into the stepper registers; the first pixel then moves into the
// output pixel register once it is free or being emptied. The single stepper that walks the error
// term gives one pixel per cycle while the output register is free or being emptied.
// A new line request is taken only once the last pixel has been stepped.
// Reset clears the controller and the output valid; the datapath has no reset.
module line_pixel_generator
	import lpg_pkg::*;
#(
	parameter int unsigned PANEL_WIDTH  = 64,
	parameter int unsigned PANEL_HEIGHT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], pixel_color[47:24]
	input  logic [47:0] s_axis_tdata,
	// to_overlay[0]
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pix_x[5:0], pix_y[11:6], pix_color[35:12], zero[39:36]
	output logic [39:0] m_axis_tdata,
	// pix_overlay[0], on_panel[1]
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	lpg_cmd_t    cmd;
	lpg_status_t status;
	coord_t      pix_x, pix_y;
	color_t      pix_color;
	logic        pix_overlay, on_panel;

	lpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.status    (status)
	);

	lpg_datapath #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.start_x     (s_axis_tdata[5:0]),
		.start_y     (s_axis_tdata[11:6]),
		.end_x       (s_axis_tdata[17:12]),
		.end_y       (s_axis_tdata[23:18]),
		.pixel_color (s_axis_tdata[47:24]),
		.to_overlay  (s_axis_tuser[0]),
		.pix_x       (pix_x),
		.pix_y       (pix_y),
		.pix_color   (pix_color),
		.pix_overlay (pix_overlay),
		.on_panel    (on_panel),
		.last_pixel  (m_axis_tlast)
	);

	assign m_axis_tdata = {4'b0000, pix_color, pix_y, pix_x};
	assign m_axis_tuser = {on_panel, pix_overlay};

endmodule

// File: sv/lpg_ctrl.sv
// ----------------------------------------------------------------------------
// lpg_ctrl
// Controller: takes a line request, then steps the datapath once per pixel
// while the output register is free or being emptied.
// ----------------------------------------------------------------------------
module lpg_ctrl
	import lpg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output lpg_cmd_t    cmd,
	input  lpg_status_t status
);

	typedef enum logic {
		IDLE,
		RUN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == IDLE);
	assign out_valid = out_valid_q;
	assign cmd.load  = in_valid && (state_q == IDLE);
	assign cmd.step  = (state_q == RUN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (cmd.load) begin
						state_q <= RUN;
					end
				end
				RUN: begin
					if (cmd.step && status.last) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	a_load_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == RUN) && !in_ready)
		else $error("line request did not start a run");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && status.last) |=> (state_q == IDLE) && out_valid_q)
		else $error("final pixel did not end the run with a valid output");

	a_no_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == IDLE) |-> !cmd.step)
		else $error("pixel step while idle");

endmodule

// File: sv/lpg_datapath.sv
// ----------------------------------------------------------------------------
// lpg_datapath
// Datapath: span and error-term setup, the Bresenham stepper and the
// output pixel register.
// ----------------------------------------------------------------------------
module lpg_datapath
	import lpg_pkg::*;
#(
	parameter int unsigned PANEL_WIDTH  = 64,
	parameter int unsigned PANEL_HEIGHT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  lpg_cmd_t    cmd,
	output lpg_status_t status,
	input  coord_t      start_x,
	input  coord_t      start_y,
	input  coord_t      end_x,
	input  coord_t      end_y,
	input  color_t      pixel_color,
	input  logic        to_overlay,
	output coord_t      pix_x,
	output coord_t      pix_y,
	output color_t      pix_color,
	output logic        pix_overlay,
	output logic        on_panel,
	output logic        last_pixel
);

	localparam logic [CoordW:0] PanelW = (CoordW+1)'(PANEL_WIDTH);
	localparam logic [CoordW:0] PanelH = (CoordW+1)'(PANEL_HEIGHT);

	coord_t               dx, dy, major, minor;
	logic                 xmaj;
	logic signed [ErrW-1:0] err_init, err_next;

	coord_t               x_q, y_q, rem_q;
	logic                 xneg_q, yneg_q, xmaj_q;
	logic [CoordW:0]      two_minor_q, two_major_q;
	logic signed [ErrW-1:0] err_q;
	color_t               color_q;
	logic                 ovl_q;

	coord_t               pix_x_q, pix_y_q;
	color_t               pix_color_q;
	logic                 pix_overlay_q, on_panel_q, last_pixel_q;

	logic                 step_x, step_y;
	coord_t               x_next, y_next;

	always_comb begin
		dx       = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
		dy       = (end_y >= start_y) ? end_y - start_y : start_y - end_y;
		xmaj     = (dx >= dy);
		major    = xmaj ? dx : dy;
		minor    = xmaj ? dy : dx;
		err_init = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
	end

	always_comb begin
		if (err_q[ErrW-1]) begin
			err_next = err_q + $signed({2'b00, two_minor_q});
			step_x   = xmaj_q;
			step_y   = !xmaj_q;
		end else begin
			err_next = err_q + $signed({2'b00, two_minor_q})
			         - $signed({2'b00, two_major_q});
			step_x   = 1'b1;
			step_y   = 1'b1;
		end
		x_next = x_q;
		y_next = y_q;
		if (step_x) begin
			x_next = xneg_q ? x_q - 1'b1 : x_q + 1'b1;
		end
		if (step_y) begin
			y_next = yneg_q ? y_q - 1'b1 : y_q + 1'b1;
		end
	end

	assign status.last = (rem_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q         <= start_x;
			y_q         <= start_y;
			xneg_q      <= (start_x > end_x);
			yneg_q      <= (start_y > end_y);
			xmaj_q      <= xmaj;
			two_minor_q <= {minor, 1'b0};
			two_major_q <= {major, 1'b0};
			err_q       <= err_init;
			rem_q       <= major;
			color_q     <= pixel_color;
			ovl_q       <= to_overlay;
		end else if (cmd.step) begin
			x_q   <= x_next;
			y_q   <= y_next;
			err_q <= err_next;
			rem_q <= rem_q - 1'b1;
		end
		if (cmd.step) begin
			pix_x_q       <= x_q;
			pix_y_q       <= y_q;
			pix_color_q   <= color_q;
			pix_overlay_q <= ovl_q;
			on_panel_q    <= ({1'b0, x_q} < PanelW) && ({1'b0, y_q} < PanelH);
			last_pixel_q  <= status.last;
		end
	end

	assign pix_x       = pix_x_q;
	assign pix_y       = pix_y_q;
	assign pix_color   = pix_color_q;
	assign pix_overlay = pix_overlay_q;
	assign on_panel    = on_panel_q;
	assign last_pixel  = last_pixel_q;

	a_rem_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && !cmd.load && !status.last) |=> rem_q == $past(rem_q) - 1'b1)
		else $error("pixel count did not decrement");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> last_pixel_q == $past(status.last))
		else $error("last pixel flag does not match the count");

endmodule

// File: tb/sv/lpg_checker.sv
// ----------------------------------------------------------------------------
// lpg_checker
// Watches both stream ports of the line pixel generator. Every line request
// taken on the input is rasterized here into the pixels it should produce,
// and every pixel request taken on the output is compared with the oldest one
// still waiting.
// ----------------------------------------------------------------------------
module lpg_checker
	import lpg_pkg::*;
#(
	parameter int unsigned PANEL_WIDTH  = 64,
	parameter int unsigned PANEL_HEIGHT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	// start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], pixel_color[47:24]
	input  logic [47:0] s_axis_tdata,
	// to_overlay[0]
	input  logic [0:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pix_x[5:0], pix_y[11:6], pix_color[35:12], zero[39:36]
	input  logic [39:0] m_axis_tdata,
	// pix_overlay[0], on_panel[1]
	input  logic [1:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          mismatches,
	output int          outstanding
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		coord_t x;
		coord_t y;
		color_t color;
		logic   overlay;
		logic   on_panel;
		logic   last;
	} pixel_t;

	pixel_t pixel_q[$];

	function automatic void plan_pixels(input logic [47:0] cmd, input logic ovl);
		int     x;
		int     y;
		int     x1;
		int     y1;
		int     dx;
		int     dy;
		int     sx;
		int     sy;
		int     major;
		int     minor;
		int     err;
		bit     xmaj;
		pixel_t p;
		x  = cmd[5:0];
		y  = cmd[11:6];
		x1 = cmd[17:12];
		y1 = cmd[23:18];
		dx = (x1 >= x) ? x1 - x : x - x1;
		dy = (y1 >= y) ? y1 - y : y - y1;
		sx = (x > x1) ? -1 : 1;
		sy = (y > y1) ? -1 : 1;
		xmaj  = dx >= dy;
		major = xmaj ? dx : dy;
		minor = xmaj ? dy : dx;
		err   = 2 * minor - major;
		for (int i = 0; i <= major; i++) begin
			p.x        = coord_t'(x);
			p.y        = coord_t'(y);
			p.color    = cmd[47:24];
			p.overlay  = ovl;
			p.on_panel = (p.x < PANEL_WIDTH) && (p.y < PANEL_HEIGHT);
			p.last     = (i == major);
			pixel_q.push_back(p);
			if (err < 0) begin
				err += 2 * minor;
				if (xmaj)
					x += sx;
				else
					y += sy;
			end else begin
				err += 2 * minor - 2 * major;
				x += sx;
				y += sy;
			end
		end
	endfunction

	always @(posedge clk) begin : watch
		pixel_t got;
		pixel_t want;
		int     errs;
		errs = mismatches;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.x        = m_axis_tdata[5:0];
				got.y        = m_axis_tdata[11:6];
				got.color    = m_axis_tdata[35:12];
				got.overlay  = m_axis_tuser[0];
				got.on_panel = m_axis_tuser[1];
				got.last     = m_axis_tlast;
				if (pixel_q.size() == 0) begin
					$display("%0t: unexpected pixel x=%0d y=%0d color=%h ovl=%b on=%b last=%b",
						$time, got.x, got.y, got.color, got.overlay, got.on_panel, got.last);
					errs++;
				end else begin
					want = pixel_q.pop_front();
					if (got !== want) begin
						$display("%0t: pixel mismatch", $time);
						$display("  expected x=%0d y=%0d color=%h ovl=%b on=%b last=%b",
							want.x, want.y, want.color, want.overlay, want.on_panel, want.last);
						$display("  actual   x=%0d y=%0d color=%h ovl=%b on=%b last=%b",
							got.x, got.y, got.color, got.overlay, got.on_panel, got.last);
						errs++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				plan_pixels(s_axis_tdata, s_axis_tuser[0]);
		end
		mismatches  <= errs;
		outstanding <= pixel_q.size();
	end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the line pixel generator. Directed lines cover the
// grid corners, single points, the longest lines and four of the octants; random
// lines follow, mostly short ones, under random idling on both ports, one
// long output stall and one full drain. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_top
	import lpg_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PanelW     = 64;
	localparam int unsigned PanelH     = 32;
	localparam int          StallLimit = 2000;
	localparam int          HoldCycles = 300;
	localparam int          NumLines   = 400;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata  = '0;
	logic [0:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int mismatches;
	int outstanding;
	int stuck      = 0;
	int hold_ask   = 0;
	int hold_done  = 0;
	bit calm       = 1'b0;

	line_pixel_generator #(
		.PANEL_WIDTH (PanelW),
		.PANEL_HEIGHT(PanelH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	lpg_checker #(
		.PANEL_WIDTH (PanelW),
		.PANEL_HEIGHT(PanelH)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stuck <= 0;
			end else if (stuck == StallLimit) begin
				$display("end of test: mismatches");
				$finish;
			end else begin
				stuck <= stuck + 1;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_ask != hold_done) begin
				hold_done = hold_ask;
				m_axis_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end else begin
				m_axis_tready <= calm || ($urandom_range(0, 99) >= 10);
			end
		end
	end

	task automatic send_line(input coord_t x0, input coord_t y0, input coord_t x1,
		input coord_t y1, input color_t color, input logic ovl);
		if (!calm) begin
			while ($urandom_range(0, 99) < 10) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {color, y1, x1, y0, x0};
		s_axis_tuser  <= ovl;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic coord_t near(input coord_t c);
		int v;
		v = int'(c) + int'($urandom_range(0, 14)) - 7;
		if (v < 0)
			v = 0;
		if (v > 63)
			v = 63;
		return coord_t'(v);
	endfunction

	initial begin : stimulus
		coord_t x0;
		coord_t y0;
		coord_t x1;
		coord_t y1;
		int     pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		send_line(0, 0, 0, 0, 24'h000000, 1'b0);
		send_line(63, 63, 63, 63, 24'hFFFFFF, 1'b1);
		send_line(0, 0, 63, 0, 24'hAAAAAA, 1'b0);
		send_line(63, 5, 0, 5, 24'h555555, 1'b1);
		send_line(10, 0, 10, 63, 24'h0F0F0F, 1'b0);
		send_line(10, 63, 10, 0, 24'hF0F0F0, 1'b1);
		send_line(0, 0, 63, 63, 24'hFFFFFF, 1'b0);
		send_line(63, 0, 0, 63, 24'h000000, 1'b1);
		send_line(0, 63, 63, 0, 24'h123456, 1'b0);
		send_line(63, 63, 0, 0, 24'hEDCBA9, 1'b1);
		send_line(0, 10, 63, 20, 24'h800001, 1'b0);
		send_line(3, 0, 20, 63, 24'h7FFFFE, 1'b1);
		send_line(40, 50, 2, 30, 24'hC3C3C3, 1'b0);
		send_line(50, 2, 30, 40, 24'h3C3C3C, 1'b1);
		send_line(5, 31, 9, 32, 24'h00FF00, 1'b0);
		drain();

		for (int i = 0; i < NumLines; i++) begin
			if (i == 100)
				hold_ask++;
			if (i == 200)
				drain();
			calm = (i >= 250) && (i < 330);
			pick = $urandom_range(0, 99);
			x0 = coord_t'($urandom_range(0, 63));
			y0 = coord_t'($urandom_range(0, 63));
			if (pick < 20) begin
				x1 = coord_t'($urandom_range(0, 63));
				y1 = coord_t'($urandom_range(0, 63));
			end else if (pick < 25) begin
				x0 = $urandom_range(0, 1) ? 6'd63 : 6'd0;
				y0 = $urandom_range(0, 1) ? 6'd63 : 6'd0;
				x1 = $urandom_range(0, 1) ? 6'd63 : 6'd0;
				y1 = $urandom_range(0, 1) ? 6'd63 : 6'd0;
			end else begin
				x1 = near(x0);
				y1 = near(y0);
			end
			send_line(x0, y0, x1, y1, color_t'($urandom), 1'($urandom_range(0, 1)));
		end
		calm = 1'b0;
		drain();
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: files.f
sv/lpg_pkg.sv
sv/lpg_ctrl.sv
sv/lpg_datapath.sv
sv/line_pixel_generator.sv
tb/sv/lpg_checker.sv
tb/sv/tb_top.sv
